// ===== src/lbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpa_pkg: shared types and constants of the largest block page allocator
// Region descriptor layout, item kinds, region type codes and sequencer states.
// ----------------------------------------------------------------------------
package lbpa_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam int TYPE_W   = 4;
  localparam int ADDR_W   = 64;
  localparam int PAGES_W  = 36;
  localparam int BYTES_W  = 48;
  localparam int COUNT_W  = 7;
  localparam int INDEX_W  = 6;

  // A page is 4096 bytes.
  localparam int PAGE_SHIFT = 12;

  localparam logic [TYPE_W-1:0] TYPE_RESERVED     = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_MMIO         = 4'd11;
  localparam logic [TYPE_W-1:0] TYPE_MMIO_PORT    = 4'd12;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ALLOC   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_TOTAL   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  rtype;
    logic [ADDR_W-1:0]  start;
    logic [PAGES_W-1:0] pages;
  } entry_t;

endpackage

// ===== src/lbpa_mem.sv =====
// ----------------------------------------------------------------------------
// lbpa_mem: region descriptor table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lbpa_mem #(
  parameter int TABLE_DEPTH = lbpa_pkg::DEFAULT_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  lbpa_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output lbpa_pkg::entry_t rdata
);

  lbpa_pkg::entry_t mem [TABLE_DEPTH];
  lbpa_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbpa_ctrl: sequencer and scan datapath
// Takes one item, scans the table via the memory read port (all but loads),
// writes back the chosen entry (allocate, release) and presents one result.
// ----------------------------------------------------------------------------
module lbpa_ctrl #(
  parameter int TABLE_DEPTH = lbpa_pkg::DEFAULT_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [lbpa_pkg::INDEX_W-1:0]  in_load_index,
  input  logic [lbpa_pkg::TYPE_W-1:0]   in_load_type,
  input  logic [lbpa_pkg::ADDR_W-1:0]   in_load_start,
  input  logic [lbpa_pkg::PAGES_W-1:0]  in_load_pages,
  input  logic [lbpa_pkg::PAGES_W-1:0]  in_request_pages,
  input  logic [lbpa_pkg::ADDR_W-1:0]   in_release_addr,
  input  logic [lbpa_pkg::COUNT_W-1:0]  entry_count,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output lbpa_pkg::entry_t              mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  lbpa_pkg::entry_t              mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_status,
  output logic [lbpa_pkg::ADDR_W-1:0]   res_granted,
  output logic [lbpa_pkg::BYTES_W-1:0]  res_total
);

  lbpa_pkg::state_t state_r, state_nxt;
  lbpa_pkg::kind_t  kind_r, kind_nxt;
  logic [lbpa_pkg::PAGES_W-1:0] req_r, req_nxt;
  logic [lbpa_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]                n_r, n_nxt;
  logic [AW-1:0]                cnt_r, cnt_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic                         found_r, found_nxt;
  logic [AW-1:0]                sel_idx_r, sel_idx_nxt;
  logic [lbpa_pkg::ADDR_W-1:0]  sel_start_r, sel_start_nxt;
  logic [lbpa_pkg::PAGES_W-1:0] sel_pages_r, sel_pages_nxt;
  logic [AW-1:0]                rd_idx_r, rd_idx_nxt;
  logic [lbpa_pkg::BYTES_W-1:0] acc_r, acc_nxt;
  logic                         status_r, status_nxt;
  logic [lbpa_pkg::ADDR_W-1:0]  granted_r, granted_nxt;
  logic [lbpa_pkg::BYTES_W-1:0] total_r, total_nxt;

  logic [CW-1:0] n_eff;
  logic          scan_last;
  logic          load_in_range;

  // Counts above the table depth act as the full table.
  assign n_eff = (int'(entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entry_count);
  assign scan_last = ((CW'(cnt_r) + CW'(1)) == n_r);
  assign load_in_range = (int'(in_load_index) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lbpa_pkg::ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    found_r     <= found_nxt;
    sel_idx_r   <= sel_idx_nxt;
    sel_start_r <= sel_start_nxt;
    sel_pages_r <= sel_pages_nxt;
    rd_idx_r    <= rd_idx_nxt;
    acc_r       <= acc_nxt;
    status_r    <= status_nxt;
    granted_r   <= granted_nxt;
    total_r     <= total_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    found_nxt     = found_r;
    sel_idx_nxt   = sel_idx_r;
    sel_start_nxt = sel_start_r;
    sel_pages_nxt = sel_pages_r;
    rd_idx_nxt    = rd_idx_r;
    acc_nxt       = acc_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    total_nxt     = total_r;

    mem_we    = 1'b0;
    mem_waddr = sel_idx_r;
    mem_wdata = '{rtype: lbpa_pkg::TYPE_RESERVED, start: sel_start_r, pages: sel_pages_r};
    mem_re    = 1'b0;
    mem_raddr = cnt_r;

    in_stall  = (state_r != lbpa_pkg::ST_IDLE) || !rst_n;
    res_valid = (state_r == lbpa_pkg::ST_FINISH);

    // Fold the entry that the memory returned in this cycle into the scan.
    if (rd_pend_r) begin
      unique case (kind_r)
        lbpa_pkg::KIND_ALLOC: begin
          // Strictly greater keeps the first of equal regions and never
          // lets an empty region win.
          if (mem_rdata.rtype == lbpa_pkg::TYPE_CONVENTIONAL &&
              mem_rdata.pages > sel_pages_r) begin
            found_nxt     = 1'b1;
            sel_idx_nxt   = rd_idx_r;
            sel_start_nxt = mem_rdata.start;
            sel_pages_nxt = mem_rdata.pages;
          end
        end
        lbpa_pkg::KIND_RELEASE: begin
          if (!found_r && addr_r != '0 && mem_rdata.start == addr_r) begin
            found_nxt     = 1'b1;
            sel_idx_nxt   = rd_idx_r;
            sel_start_nxt = mem_rdata.start;
            sel_pages_nxt = mem_rdata.pages;
          end
        end
        lbpa_pkg::KIND_TOTAL: begin
          if (mem_rdata.rtype != lbpa_pkg::TYPE_MMIO &&
              mem_rdata.rtype != lbpa_pkg::TYPE_MMIO_PORT) begin
            acc_nxt = acc_r + (lbpa_pkg::BYTES_W'(mem_rdata.pages) << lbpa_pkg::PAGE_SHIFT);
          end
        end
        lbpa_pkg::KIND_LOAD: begin
        end
      endcase
    end

    unique case (state_r)
      lbpa_pkg::ST_IDLE: begin
        if (in_valid && rst_n) begin
          kind_nxt      = lbpa_pkg::kind_t'(in_kind);
          req_nxt       = in_request_pages;
          addr_nxt      = in_release_addr;
          n_nxt         = n_eff;
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          sel_pages_nxt = '0;
          acc_nxt       = '0;
          status_nxt    = 1'b0;
          granted_nxt   = '0;
          total_nxt     = '0;
          if (lbpa_pkg::kind_t'(in_kind) == lbpa_pkg::KIND_LOAD) begin
            mem_we    = load_in_range;
            mem_waddr = AW'(in_load_index);
            mem_wdata = '{rtype: in_load_type, start: in_load_start, pages: in_load_pages};
            state_nxt = lbpa_pkg::ST_FINISH;
          end else if (n_eff == '0) begin
            state_nxt = lbpa_pkg::ST_COMMIT;
          end else begin
            state_nxt = lbpa_pkg::ST_SCAN;
          end
        end
      end
      lbpa_pkg::ST_SCAN: begin
        mem_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        rd_idx_nxt  = cnt_r;
        cnt_nxt     = cnt_r + AW'(1);
        if (scan_last) begin
          state_nxt = lbpa_pkg::ST_DRAIN;
        end
      end
      lbpa_pkg::ST_DRAIN: begin
        state_nxt = lbpa_pkg::ST_COMMIT;
      end
      lbpa_pkg::ST_COMMIT: begin
        unique case (kind_r)
          lbpa_pkg::KIND_ALLOC: begin
            if (found_r && sel_pages_r >= req_r) begin
              mem_we      = 1'b1;
              granted_nxt = sel_start_r;
              status_nxt  = 1'b0;
            end else begin
              status_nxt  = 1'b1;
            end
          end
          lbpa_pkg::KIND_RELEASE: begin
            mem_wdata.rtype = lbpa_pkg::TYPE_CONVENTIONAL;
            mem_we          = found_r;
            status_nxt      = !found_r;
          end
          lbpa_pkg::KIND_TOTAL: begin
            total_nxt = acc_r;
          end
          lbpa_pkg::KIND_LOAD: begin
          end
        endcase
        state_nxt = lbpa_pkg::ST_FINISH;
      end
      lbpa_pkg::ST_FINISH: begin
        if (res_ready) begin
          state_nxt = lbpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_status  = status_r;
  assign res_granted = granted_r;
  assign res_total   = total_r;

endmodule

// ===== src/largest_block_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// largest_block_page_allocator_unit: worst-fit page allocator over a table
// of memory region descriptors, with a load, allocate, release and total
// command set.
// ----------------------------------------------------------------------------
// Usage: an input item carries a kind and the fields that kind needs; every
// item yields exactly one result item (status, granted address, byte total).
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The entry count register is written over the cfg_ channel; the user
// must write it only while the block is idle, which the block does not enforce.
//
// Sequence: a load item writes its entry as it is accepted and then presents
// its result. Allocate, release and total scan the n entries in use through
// the table's single read port, one entry per cycle, where n is at most
// TABLE_DEPTH; with no entry in use they skip the scan. The block holds
// one item at a time; in_stall is high from acceptance until the result has
// moved into the output register.
//
// The output register frees the sequencer: a new item is taken while a
// finished result still waits on out_stall; that item then waits in its own
// final cycle until the output register is free.
//
// Reset clears the entry count to zero, the sequencer to idle and the output
// valid. Table entries have no reset and must be loaded before they are used.
// ----------------------------------------------------------------------------
module largest_block_page_allocator_unit #(
  parameter int TABLE_DEPTH = lbpa_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbpa_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [lbpa_pkg::INDEX_W-1:0]  in_load_index,
  input  logic [lbpa_pkg::TYPE_W-1:0]   in_load_type,
  input  logic [lbpa_pkg::ADDR_W-1:0]   in_load_start,
  input  logic [lbpa_pkg::PAGES_W-1:0]  in_load_pages,
  input  logic [lbpa_pkg::PAGES_W-1:0]  in_request_pages,
  input  logic [lbpa_pkg::ADDR_W-1:0]   in_release_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [lbpa_pkg::ADDR_W-1:0]   out_granted_addr,
  output logic [lbpa_pkg::BYTES_W-1:0]  out_total_bytes
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // Entry count register; the port takes a write in every cycle out of reset.
  logic [lbpa_pkg::COUNT_W-1:0] entry_count_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_data;
    end
  end

  // Table memory and sequencer.
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  lbpa_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  lbpa_pkg::entry_t mem_rdata;

  logic                         res_valid;
  logic                         res_ready;
  logic                         res_status;
  logic [lbpa_pkg::ADDR_W-1:0]  res_granted;
  logic [lbpa_pkg::BYTES_W-1:0] res_total;

  lbpa_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lbpa_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_load_index    (in_load_index),
    .in_load_type     (in_load_type),
    .in_load_start    (in_load_start),
    .in_load_pages    (in_load_pages),
    .in_request_pages (in_request_pages),
    .in_release_addr  (in_release_addr),
    .entry_count      (entry_count_r),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_status       (res_status),
    .res_granted      (res_granted),
    .res_total        (res_total)
  );

  // Output register. It loads whenever it is empty or its item leaves in
  // this cycle, so a stalled receiver only holds the sequencer in its final
  // state and never drops or repeats a result.
  logic                         out_valid_r;
  logic                         out_status_r;
  logic [lbpa_pkg::ADDR_W-1:0]  out_granted_r;
  logic [lbpa_pkg::BYTES_W-1:0] out_total_r;

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_status_r  <= res_status;
      out_granted_r <= res_granted;
      out_total_r   <= res_total;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_addr = out_granted_r;
  assign out_total_bytes  = out_total_r;

endmodule

// ===== src/lbpa_chk.sv =====
// ----------------------------------------------------------------------------
// lbpa_chk: port-level checks for the largest block page allocator
// Watches the top level's ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module lbpa_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_status,
  input logic [lbpa_pkg::ADDR_W-1:0]   out_granted_addr,
  input logic [lbpa_pkg::BYTES_W-1:0]  out_total_bytes
);

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in two consecutive cycles");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Only a successful allocate grants an address, and it reports no total.
  a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted_addr != '0 |-> !out_status && out_total_bytes == '0)
    else $error("granted address on a result that is not a successful allocate");

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind largest_block_page_allocator_unit lbpa_chk u_lbpa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_granted_addr (out_granted_addr),
  .out_total_bytes  (out_total_bytes)
);
